[rtl/contiguous_frame_allocator_defines.svh]
// assertion macros shared by the frame allocator modules
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define CFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define CFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cfa_pkg.sv]
package cfa_pkg;

    // default sizes of the frame map
    localparam int unsigned NUM_FRAMES_DEF = 1024;
    localparam int unsigned PAGE_BYTES_DEF = 4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 1'b1;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOMEM     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_ADDR = 2'd2;

    // one entry of the frame map
    typedef struct packed {
        logic in_use;
        logic chained;
    } t_frame;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_ALLOC,
        ST_SCAN_FREE,
        ST_FILL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_alloc;
        logic scan_free;
        logic fill;
        logic clear;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic        clear_last;
        logic        scan_end;
        logic        alloc_hit;
        logic        free_stop;
        logic        fill_last;
        logic [31:0] start_addr;
    } t_dp_sts;

endpackage

[rtl/cfa_ram.sv]
module cfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/cfa_ctrl.sv]
`include "contiguous_frame_allocator_defines.svh"

module cfa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_op,
    input  logic [10:0]     i_page_count,
    input  logic [31:0]     i_frame_addr,
    output cfa_pkg::t_dp_cmd o_cmd,
    input  cfa_pkg::t_dp_sts i_sts,
    output logic            o_result_valid,
    output logic [1:0]      o_status,
    output logic [31:0]     o_alloc_addr
);

    cfa_pkg::t_state r_state, n_state;
    logic            r_done, n_done;
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_addr, n_addr;

    // state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::ST_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = r_status;
        n_addr   = r_addr;
        o_cmd    = '0;
        case (r_state)
            cfa_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = cfa_pkg::ST_IDLE;
                end
            end
            cfa_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_op == cfa_pkg::OP_FREE) begin
                        if (i_frame_addr == '0) begin
                            n_done   = 1'b1;
                            n_status = cfa_pkg::STATUS_ZERO_ADDR;
                            n_addr   = '0;
                        end else begin
                            o_cmd.load = 1'b1;
                            n_state    = cfa_pkg::ST_SCAN_FREE;
                        end
                    end else begin
                        if (i_page_count == '0) begin
                            n_done   = 1'b1;
                            n_status = cfa_pkg::STATUS_NOMEM;
                            n_addr   = '0;
                        end else begin
                            o_cmd.load = 1'b1;
                            n_state    = cfa_pkg::ST_SCAN_ALLOC;
                        end
                    end
                end
            end
            cfa_pkg::ST_SCAN_ALLOC: begin
                o_cmd.scan_alloc = 1'b1;
                if (i_sts.alloc_hit) begin
                    n_state = cfa_pkg::ST_FILL;
                end else if (i_sts.scan_end) begin
                    n_done   = 1'b1;
                    n_status = cfa_pkg::STATUS_NOMEM;
                    n_addr   = '0;
                    n_state  = cfa_pkg::ST_IDLE;
                end
            end
            cfa_pkg::ST_SCAN_FREE: begin
                o_cmd.scan_free = 1'b1;
                if (i_sts.free_stop || i_sts.scan_end) begin
                    n_done   = 1'b1;
                    n_status = cfa_pkg::STATUS_OK;
                    n_addr   = '0;
                    n_state  = cfa_pkg::ST_IDLE;
                end
            end
            cfa_pkg::ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_done   = 1'b1;
                    n_status = cfa_pkg::STATUS_OK;
                    n_addr   = i_sts.start_addr;
                    n_state  = cfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != cfa_pkg::ST_IDLE);
    assign o_result_valid = r_done;
    assign o_status       = r_status;
    assign o_alloc_addr   = r_addr;

    // checks
    `CFA_ASSERT_NEXT(a_start_takes_effect, i_clk, i_rst_n, start && !busy, busy || o_result_valid, "accepted request neither started work nor finished")
    `CFA_ASSERT_NEXT(a_fill_ends_ok, i_clk, i_rst_n, (r_state == cfa_pkg::ST_FILL) && i_sts.fill_last, o_result_valid && (o_status == cfa_pkg::STATUS_OK), "fill did not end in an ok result")
    `CFA_ASSERT_IMPL(a_fail_has_no_addr, i_clk, i_rst_n, o_result_valid && (o_status != cfa_pkg::STATUS_OK), o_alloc_addr == '0, "failed request returned an address")

endmodule

[rtl/cfa_datapath.sv]
`include "contiguous_frame_allocator_defines.svh"

module cfa_datapath #(
    parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BYTES = cfa_pkg::PAGE_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfa_pkg::t_dp_cmd i_cmd,
    output cfa_pkg::t_dp_sts o_sts,
    input  logic [31:0]      i_base_address,
    input  logic [10:0]      i_frame_count,
    input  logic [10:0]      i_page_count,
    input  logic [31:0]      i_frame_addr
);

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int IW = $clog2(NUM_FRAMES + 1);
    localparam int NW = (IW > 11) ? IW : 11;
    localparam int FW = $bits(cfa_pkg::t_frame);
    localparam logic [31:0] PAGE_INC = 32'(PAGE_BYTES);

    logic [IW-1:0]   r_n;
    logic [10:0]     r_pages;
    logic [31:0]     r_faddr;
    logic [IW-1:0]   r_rd_idx;
    logic            r_ev_valid;
    logic [AW-1:0]   r_ev_idx;
    logic [31:0]     r_cur_addr;
    logic [IW-1:0]   r_run;
    logic [AW-1:0]   r_run_start_idx;
    logic [31:0]     r_run_start_addr;
    logic            r_found;
    logic [AW-1:0]   r_fill_idx;
    logic [AW-1:0]   r_fill_end;
    logic [AW-1:0]   r_clr_idx;

    logic [IW-1:0]   w_n;
    logic            w_scan;
    logic            w_issue;
    logic [IW-1:0]   w_run_n;
    logic            w_alloc_hit;
    logic            w_free_hit;
    logic [31:0]     w_next_addr;
    cfa_pkg::t_frame w_frame;
    cfa_pkg::t_frame w_wframe;
    logic [FW-1:0]   w_rdata;
    logic            w_ram_we;
    logic [AW-1:0]   w_waddr;

    // active map size, oversized counts clamp to the map
    assign w_n = (NW'(i_frame_count) > NW'(NUM_FRAMES)) ? IW'(NUM_FRAMES) : IW'(i_frame_count);

    // scan evaluation on the frame read last cycle
    assign w_scan      = i_cmd.scan_alloc || i_cmd.scan_free;
    assign w_issue     = (r_rd_idx < r_n);
    assign w_frame     = cfa_pkg::t_frame'(w_rdata);
    assign w_next_addr = r_cur_addr + PAGE_INC;
    assign w_run_n     = w_frame.in_use ? '0 : r_run + 1'b1;
    assign w_alloc_hit = r_ev_valid && !w_frame.in_use && (NW'(w_run_n) == NW'(r_pages));
    assign w_free_hit  = r_ev_valid && (r_found || (r_cur_addr == r_faddr));

    // status back to the controller
    assign o_sts.clear_last = (r_clr_idx == AW'(NUM_FRAMES - 1));
    assign o_sts.scan_end   = !r_ev_valid && !w_issue;
    assign o_sts.alloc_hit  = w_alloc_hit;
    assign o_sts.free_stop  = w_free_hit && !w_frame.chained;
    assign o_sts.fill_last  = (r_fill_idx == r_fill_end);
    assign o_sts.start_addr = r_run_start_addr;

    // map write port: clearing pass, run fill, or free of a block
    always_comb begin
        w_ram_we = 1'b0;
        w_waddr  = r_ev_idx;
        w_wframe = '0;
        if (i_cmd.clear) begin
            w_ram_we = 1'b1;
            w_waddr  = r_clr_idx;
        end else if (i_cmd.fill) begin
            w_ram_we         = 1'b1;
            w_waddr          = r_fill_idx;
            w_wframe.in_use  = 1'b1;
            w_wframe.chained = (r_fill_idx != r_fill_end);
        end else if (i_cmd.scan_free && w_free_hit) begin
            w_ram_we         = 1'b1;
            w_wframe.chained = w_frame.chained;
        end
    end

    cfa_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_FRAMES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wframe),
        .i_re    (w_scan && w_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_ev_valid <= 1'b0;
            r_rd_idx   <= '0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_rd_idx   <= '0;
                r_ev_valid <= 1'b0;
                r_found    <= 1'b0;
            end else if (w_scan) begin
                if (w_issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                r_ev_valid <= w_issue;
                if (w_free_hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // request and scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n              <= w_n;
            r_pages          <= i_page_count;
            r_faddr          <= i_frame_addr;
            r_cur_addr       <= i_base_address;
            r_run            <= '0;
            r_run_start_idx  <= '0;
            r_run_start_addr <= i_base_address;
        end else if (w_scan) begin
            r_ev_idx <= r_rd_idx[AW-1:0];
            if (r_ev_valid) begin
                r_cur_addr <= w_next_addr;
                r_run      <= w_run_n;
                if (w_frame.in_use) begin
                    r_run_start_idx  <= r_ev_idx + 1'b1;
                    r_run_start_addr <= w_next_addr;
                end
            end
            if (i_cmd.scan_alloc && w_alloc_hit) begin
                r_fill_idx <= r_run_start_idx;
                r_fill_end <= r_ev_idx;
            end
        end
        if (i_cmd.fill) begin
            r_fill_idx <= r_fill_idx + 1'b1;
        end
    end

    // checks
    `CFA_ASSERT_IMPL(a_no_write_in_alloc_scan, i_clk, i_rst_n, i_cmd.scan_alloc, !w_ram_we, "map written during allocate search")
    `CFA_ASSERT_IMPL(a_fill_within_run, i_clk, i_rst_n, i_cmd.fill, r_fill_idx <= r_fill_end, "fill index ran past the end of the run")

endmodule

[rtl/contiguous_frame_allocator.sv]
// channel    | direction | handshake                     | payload
// -----------+-----------+-------------------------------+-------------------------------
// request    | in        | start and !busy               | i_op, i_page_count, i_frame_addr
// result     | out       | o_result_valid, one cycle     | o_status, o_alloc_addr
// config     | in        | i_cfg_valid and o_cfg_ready   | i_cfg_index, i_cfg_data
//
// after reset the map is cleared one frame a cycle; busy stays high until the clear is done.
// allocate: load, then search the active frames for the first free run of the asked length,
// then mark the run in use; free: scan to the given frame address and free frames along its chain.
// the frame map memory has one read and one write port, which sets the one frame a cycle.
// the result strobe comes the cycle after the work ends; the receiver cannot stall it.
// config writes are always taken; o_cfg_ready is held high.
module contiguous_frame_allocator #(
    parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_BYTES = cfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [10:0]                   i_page_count,
    input  logic [31:0]                   i_frame_addr,
    output logic                          o_result_valid,
    output logic [1:0]                    o_status,
    output logic [31:0]                   o_alloc_addr,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic [31:0]      r_base_address;
    logic [10:0]      r_frame_count;
    cfa_pkg::t_dp_cmd w_cmd;
    cfa_pkg::t_dp_sts w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= '0;
            r_frame_count  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cfa_pkg::CFG_BASE_ADDRESS: r_base_address <= i_cfg_data;
                cfa_pkg::CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencing
    cfa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_page_count   (i_page_count),
        .i_frame_addr   (i_frame_addr),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_alloc_addr   (o_alloc_addr)
    );

    // frame map and scan logic
    cfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_base_address (r_base_address),
        .i_frame_count  (r_frame_count),
        .i_page_count   (i_page_count),
        .i_frame_addr   (i_frame_addr)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cfa_pkg::*;

    localparam int MAP_FRAMES    = NUM_FRAMES_DEF;
    localparam int FRAME_BYTES   = PAGE_BYTES_DEF;
    localparam int DRAIN_CYCLES  = 2 * MAP_FRAMES + 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PRINT_CAP     = 100;

    typedef enum logic { CMD_REQUEST, CMD_REG_WRITE } t_cmd_kind;

    // one entry of the stimulus list: a request or a register write
    typedef struct {
        t_cmd_kind             kind;
        logic                  op;
        logic [10:0]           pages;
        logic [31:0]           addr;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [31:0]           reg_data;
        int unsigned           gap;
    } t_map_cmd;

    // predicted outcome of one request
    typedef struct {
        int unsigned seq;
        logic [1:0]  status;
        logic [31:0] addr;
    } t_map_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic                 i_op         = OP_ALLOC;
    logic [10:0]          i_page_count = '0;
    logic [31:0]          i_frame_addr = '0;
    logic                 o_result_valid;
    logic [1:0]           o_status;
    logic [31:0]          o_alloc_addr;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [31:0]          i_cfg_data   = '0;

    // stimulus list, predicted outcomes and bookkeeping
    t_map_cmd    map_cmds[$];
    t_map_result frame_op_results[$];
    int unsigned req_issued   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_cnt    = 0;
    longint      cycle_budget = 0;
    longint      cycle_limit  = 0;
    logic        stim_done    = 1'b0;

    // planning copy of the configuration while the list is built
    logic        gaps_on     = 1'b1;
    logic [31:0] plan_base   = '0;
    int          plan_frames = 0;

    // predictor state: frame map and registers
    logic        frame_used [MAP_FRAMES];
    logic        frame_link [MAP_FRAMES];
    logic [31:0] map_base   = '0;
    logic [10:0] map_frames = '0;

    contiguous_frame_allocator #(
        .NUM_FRAMES(MAP_FRAMES),
        .PAGE_BYTES(FRAME_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_page_count   (i_page_count),
        .i_frame_addr   (i_frame_addr),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_alloc_addr   (o_alloc_addr),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // address of frame idx, wrapping at 32 bits
    function automatic logic [31:0] page_addr(input logic [31:0] base, input int idx);
        return base + 32'(idx) * 32'(FRAME_BYTES);
    endfunction

    // first-fit allocate or chained free on the predictor's map
    function automatic t_map_result apply_frame_op(input logic op, input logic [10:0] pages,
                                                   input logic [31:0] addr);
        t_map_result res;
        int          n;
        int          run;
        int          hit;
        int          first;
        int          i;
        logic        found;
        n = (map_frames > MAP_FRAMES) ? MAP_FRAMES : int'(map_frames);
        res.seq = req_issued;
        res.status = STATUS_OK;
        res.addr = '0;
        found = 1'b0;
        if (op == OP_ALLOC) begin
            res.status = STATUS_NOMEM;
            hit = -1;
            run = 0;
            if (pages != 0) begin
                for (i = 0; i < n && hit < 0; i++) begin
                    run = frame_used[i] ? 0 : run + 1;
                    if (run == int'(pages))
                        hit = i;
                end
            end
            if (hit >= 0) begin
                first = hit + 1 - int'(pages);
                for (i = first; i <= hit; i++) begin
                    frame_used[i] = 1'b1;
                    frame_link[i] = (i < hit);
                end
                res.status = STATUS_OK;
                res.addr = page_addr(map_base, first);
            end
        end else if (addr == '0) begin
            res.status = STATUS_ZERO_ADDR;
        end else begin
            for (i = 0; i < n; i++) begin
                if (!found && page_addr(map_base, i) == addr)
                    found = 1'b1;
                if (found) begin
                    frame_used[i] = 1'b0;
                    if (!frame_link[i])
                        break;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // idle burst ahead of a list entry
    function automatic int unsigned pick_gap();
        if (gaps_on && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    task automatic queue_request(input logic op, input logic [10:0] pages,
                                 input logic [31:0] addr);
        t_map_cmd cmd;
        cmd.kind = CMD_REQUEST;
        cmd.op = op;
        cmd.pages = pages;
        cmd.addr = addr;
        cmd.reg_idx = '0;
        cmd.reg_data = '0;
        cmd.gap = pick_gap();
        map_cmds.push_back(cmd);
        cycle_budget += 2 * plan_frames + 64 + cmd.gap;
    endtask

    task automatic queue_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_map_cmd cmd;
        cmd.kind = CMD_REG_WRITE;
        cmd.op = OP_ALLOC;
        cmd.pages = '0;
        cmd.addr = '0;
        cmd.reg_idx = idx;
        cmd.reg_data = data;
        cmd.gap = pick_gap();
        map_cmds.push_back(cmd);
        cycle_budget += 16 + cmd.gap;
        if (idx == CFG_BASE_ADDRESS)
            plan_base = data;
        else
            plan_frames = (data[10:0] > MAP_FRAMES) ? MAP_FRAMES : int'(data[10:0]);
    endtask

    // driver: requests and register writes from the list, predictor updated on acceptance
    always @(posedge i_clk) begin : drive_proc
        t_map_cmd    nxt;
        logic        have_next;
        int unsigned gap_left;
        logic        req_taken;
        logic        cfg_taken;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            have_next = 1'b0;
            gap_left = 0;
            for (int k = 0; k < MAP_FRAMES; k++) begin
                frame_used[k] = 1'b0;
                frame_link[k] = 1'b0;
            end
            map_base = '0;
            map_frames = '0;
        end else begin
            req_taken = start && !busy;
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (req_taken) begin
                frame_op_results.push_back(apply_frame_op(i_op, i_page_count, i_frame_addr));
                req_issued++;
            end
            if (cfg_taken) begin
                if (i_cfg_index == CFG_BASE_ADDRESS)
                    map_base = i_cfg_data;
                else
                    map_frames = i_cfg_data[10:0];
            end
            // a request or write still waiting keeps the bus as it is
            if (!((start && !req_taken) || (i_cfg_valid && !cfg_taken))) begin
                if (!have_next && map_cmds.size() > 0) begin
                    nxt = map_cmds.pop_front();
                    have_next = 1'b1;
                    gap_left = nxt.gap;
                end
                if (!have_next) begin
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                    stim_done <= 1'b1;
                end else if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (nxt.kind == CMD_REQUEST) begin
                    start <= 1'b1;
                    i_cfg_valid <= 1'b0;
                    i_op <= nxt.op;
                    i_page_count <= nxt.pages;
                    i_frame_addr <= nxt.addr;
                    have_next = 1'b0;
                end else if (req_issued == results_seen && !busy && !o_result_valid) begin
                    // register writes only once every result is back
                    start <= 1'b0;
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= nxt.reg_idx;
                    i_cfg_data <= nxt.reg_data;
                    have_next = 1'b0;
                end else begin
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: each result strobe against the oldest prediction
    always @(posedge i_clk) begin : check_proc
        t_map_result want;
        if (i_rst_n && o_result_valid) begin
            results_seen <= results_seen + 1;
            if (frame_op_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: status %0d addr %h",
                                          o_status, o_alloc_addr));
            end else begin
                want = frame_op_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("request %0d status %0d, expected %0d",
                                              want.seq, o_status, want.status));
                if (o_alloc_addr !== want.addr)
                    report_mismatch($sformatf("request %0d alloc_addr %h, expected %h",
                                              want.seq, o_alloc_addr, want.addr));
            end
        end
    end

    // timeout
    initial begin
        @(posedge i_clk);
        while (cycle_cnt < cycle_limit)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // stimulus list, reset and end of run
    initial begin
        int          phase;
        int          items;
        int          count;
        int          pick;
        logic [31:0] base;
        logic [31:0] addr;
        logic [10:0] pages;

        cycle_budget = MAP_FRAMES + 16;

        // empty map straight out of reset
        gaps_on = 1'b1;
        queue_request(OP_ALLOC, 11'd1, $urandom);
        queue_request(OP_FREE, 11'($urandom), 32'h0000_1000);
        queue_request(OP_FREE, 11'($urandom), 32'h0);

        // small map: zero pages, fits, run past the end, unknown address
        queue_reg_write(CFG_BASE_ADDRESS, 32'h8000_0000);
        queue_reg_write(CFG_FRAME_COUNT, 32'd8);
        queue_request(OP_ALLOC, 11'd0, $urandom);
        queue_request(OP_ALLOC, 11'd3, $urandom);
        queue_request(OP_ALLOC, 11'd2, $urandom);
        queue_request(OP_ALLOC, 11'd4, $urandom);
        queue_request(OP_ALLOC, 11'd3, $urandom);
        queue_request(OP_FREE, 11'($urandom), page_addr(plan_base, 3));
        queue_request(OP_ALLOC, 11'd1, $urandom);
        queue_request(OP_FREE, 11'($urandom), 32'h0);
        queue_request(OP_FREE, 11'($urandom), plan_base + 32'h10);
        queue_request(OP_FREE, 11'($urandom), page_addr(plan_base, 7));
        queue_request(OP_FREE, 11'($urandom), page_addr(plan_base, 0));
        queue_request(OP_ALLOC, 11'h7FF, $urandom);
        queue_request(OP_ALLOC, 11'd1024, $urandom);

        // oversized frame count, base at the top of the address space
        queue_reg_write(CFG_BASE_ADDRESS, 32'hFFFF_F000);
        queue_reg_write(CFG_FRAME_COUNT, 32'h7FF);
        queue_request(OP_ALLOC, 11'd1024, $urandom);
        queue_request(OP_ALLOC, 11'd1, $urandom);
        queue_request(OP_FREE, 11'($urandom), 32'hFFFF_F000);
        queue_request(OP_FREE, 11'($urandom), 32'hFFFF_FFFF);

        // shrunk map cuts a chained free short, frame zero at address zero
        queue_reg_write(CFG_BASE_ADDRESS, 32'h0);
        queue_reg_write(CFG_FRAME_COUNT, 32'd16);
        queue_request(OP_ALLOC, 11'd12, $urandom);
        queue_request(OP_ALLOC, 11'd4, $urandom);
        queue_reg_write(CFG_FRAME_COUNT, 32'd14);
        queue_request(OP_FREE, 11'($urandom), page_addr(plan_base, 12));
        queue_reg_write(CFG_FRAME_COUNT, 32'd16);
        queue_request(OP_ALLOC, 11'd2, $urandom);
        queue_request(OP_FREE, 11'($urandom), page_addr(plan_base, 0));

        // random phases, each with its own map setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            gaps_on = (phase % 3 != 2) && (phase != RANDOM_PHASES - 1);
            case (phase)
                3:       count = MAP_FRAMES;
                5:       count = 1;
                8:       count = 11'h7FF;
                9:       count = 0;
                default: count = $urandom_range(2, 64);
            endcase
            case ($urandom_range(0, 4))
                0:       base = 32'h0;
                1:       base = 32'hFFFF_F000;
                2:       base = $urandom;
                default: base = $urandom & ~32'(FRAME_BYTES - 1);
            endcase
            if ($urandom_range(0, 1)) begin
                queue_reg_write(CFG_BASE_ADDRESS, base);
                queue_reg_write(CFG_FRAME_COUNT, ($urandom & 32'hFFFF_F800) | 32'(count));
            end else begin
                queue_reg_write(CFG_FRAME_COUNT, ($urandom & 32'hFFFF_F800) | 32'(count));
                queue_reg_write(CFG_BASE_ADDRESS, base);
            end
            items = (count > 64) ? 24 : 53;
            repeat (items) begin
                if ($urandom_range(0, 99) < 55) begin
                    // allocate: mostly small runs, some large or out of range
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        pages = 11'($urandom_range(1, plan_frames / 4 + 1));
                    else if (pick < 85)
                        pages = 11'($urandom_range(1, plan_frames + 1));
                    else if (pick < 95)
                        pages = 11'($urandom_range(0, 11'h7FF));
                    else
                        pages = 11'(plan_frames);
                    queue_request(OP_ALLOC, pages, $urandom);
                end else begin
                    // free: mostly frame addresses inside the map
                    pick = $urandom_range(0, 99);
                    addr = page_addr(plan_base,
                                     $urandom_range(0, (plan_frames > 0) ? plan_frames - 1 : 0));
                    if (pick >= 70 && pick < 80)
                        addr = 32'h0;
                    else if (pick >= 80 && pick < 90)
                        addr = $urandom;
                    else if (pick >= 90)
                        addr = addr + 32'($urandom_range(1, FRAME_BYTES - 1));
                    queue_request(OP_FREE, 11'($urandom), addr);
                end
            end
        end
        cycle_limit = 4 * cycle_budget + DRAIN_CYCLES;

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the list to drain and every result to come back
        while (!(stim_done && frame_op_results.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_op_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/cfa_ctrl.sv
rtl/cfa_datapath.sv
rtl/contiguous_frame_allocator.sv
tb/testbench.sv
